// File: rtl/fjop_pkg.sv
package fjop_pkg;

  typedef enum logic [3:0] {
    PH_OPEN  = 4'd0,
    PH_FIRST = 4'd1,
    PH_KEY   = 4'd2,
    PH_KBODY = 4'd3,
    PH_COLON = 4'd4,
    PH_VALUE = 4'd5,
    PH_SBODY = 4'd6,
    PH_LIT   = 4'd7,
    PH_NUM   = 4'd8,
    PH_AFTER = 4'd9,
    PH_DONE  = 4'd10
  } phase_e;

  // Result event codes
  localparam logic [2:0] EV_KEY  = 3'd0;
  localparam logic [2:0] EV_STR  = 3'd1;
  localparam logic [2:0] EV_PAIR = 3'd2;
  localparam logic [2:0] EV_OK   = 3'd3;
  localparam logic [2:0] EV_ERR  = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_OBJECT = 3'd0;
  localparam logic [2:0] ERR_PAIRS  = 3'd1;
  localparam logic [2:0] ERR_KEY    = 3'd2;
  localparam logic [2:0] ERR_COLON  = 3'd3;
  localparam logic [2:0] ERR_STRING = 3'd4;
  localparam logic [2:0] ERR_VALUE  = 3'd5;
  localparam logic [2:0] ERR_AFTER  = 3'd6;

  // Value kinds
  localparam logic [1:0] KIND_STRING = 2'd0;
  localparam logic [1:0] KIND_INT    = 2'd1;
  localparam logic [1:0] KIND_BOOL   = 2'd2;
  localparam logic [1:0] KIND_NULL   = 2'd3;

  // Literal selectors
  localparam logic [1:0] LIT_TRUE  = 2'd0;
  localparam logic [1:0] LIT_FALSE = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PAIR_LIMIT = 2'd0;
  localparam logic [1:0] REG_KEY_KEEP   = 2'd1;
  localparam logic [1:0] REG_STR_KEEP   = 2'd2;

  localparam logic [7:0] PAIR_LIMIT_RST = 8'd16;
  localparam logic [7:0] KEY_KEEP_RST   = 8'd31;
  localparam logic [7:0] STR_KEEP_RST   = 8'd127;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [63:0] MAG_CAP = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [7:0] pair_limit;
    logic [7:0] key_keep;
    logic [7:0] str_keep;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  text;
    logic [1:0]  kind;
    logic [63:0] num;
    logic        flag;
    logic [7:0]  idx;
    logic [2:0]  err;
    logic        last;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    logic [2:0] len;
    case (w)
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  // Byte p of literal w; position 0 is the opening letter, matched elsewhere
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    case ({w, p})
      {LIT_TRUE, 3'd1}:  c = CH_LOW_R;
      {LIT_TRUE, 3'd2}:  c = CH_LOW_U;
      {LIT_TRUE, 3'd3}:  c = CH_LOW_E;
      {LIT_FALSE, 3'd1}: c = CH_LOW_A;
      {LIT_FALSE, 3'd2}: c = CH_LOW_L;
      {LIT_FALSE, 3'd3}: c = CH_LOW_S;
      {LIT_FALSE, 3'd4}: c = CH_LOW_E;
      {LIT_NULL, 3'd1}:  c = CH_LOW_U;
      {LIT_NULL, 3'd2}:  c = CH_LOW_L;
      {LIT_NULL, 3'd3}:  c = CH_LOW_L;
      default:           c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic res_t mk_err(input logic [2:0] code);
    res_t r;
    r     = '0;
    r.ev  = EV_ERR;
    r.err = code;
    return r;
  endfunction

  function automatic res_t mk_ok(input logic [7:0] idx);
    res_t r;
    r     = '0;
    r.ev  = EV_OK;
    r.idx = idx;
    return r;
  endfunction

  function automatic res_t mk_pair(input logic [1:0] kind, input logic [63:0] num,
                                   input logic flag, input logic [7:0] idx);
    res_t r;
    r      = '0;
    r.ev   = EV_PAIR;
    r.kind = kind;
    r.num  = num;
    r.flag = flag;
    r.idx  = idx;
    return r;
  endfunction

  function automatic res_t mk_text(input logic [2:0] ev, input logic [7:0] c,
                                   input logic [7:0] idx);
    res_t r;
    r      = '0;
    r.ev   = ev;
    r.text = c;
    r.idx  = idx;
    return r;
  endfunction

endpackage

// File: rtl/flat_json_object_parser.sv
// Flat JSON object parser: takes one text byte per transfer and streams out key bytes,
// string bytes, pair-done records, and a final doc-ok or error record, one per transfer.
// A byte enters an input register, is parsed from there against the document state,
// and any results it yields (none, one or two) land in a ResDepth-entry result queue,
// whose head result is offered on the output. Input is taken every cycle while the
// queue has room for two results, so the input rate is one byte per clock as long as
// the output side takes results at least as fast as they are produced; a byte that
// ends a number and is a closing brace or a stray byte yields two results, a pair-done
// and then a doc-ok or error record. Configuration registers are to be written only
// while the parser is idle (the block itself does not enforce this) and take effect
// on the next parsed byte.
module flat_json_object_parser import fjop_pkg::*; #(
  parameter int ResDepth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        ch_i,
  input  logic              start_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        event_res_o,
  output logic [7:0]        text_char_o,
  output logic [1:0]        value_kind_o,
  output logic signed [63:0] number_o,
  output logic              flag_value_o,
  output logic [7:0]        pair_index_o,
  output logic [2:0]        error_code_o,
  output logic              last_o
);

  cfg_t       cfg_q;
  logic       s1_valid_q;
  logic [7:0] s1_ch_q;
  logic       s1_start_q;
  logic       advance;
  logic       room;
  res_t       res0, res1, head;
  logic [1:0] res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pair_limit <= PAIR_LIMIT_RST;
      cfg_q.key_keep   <= KEY_KEEP_RST;
      cfg_q.str_keep   <= STR_KEEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAIR_LIMIT: cfg_q.pair_limit <= cfg_data_i;
        REG_KEY_KEEP:   cfg_q.key_keep   <= cfg_data_i;
        REG_STR_KEEP:   cfg_q.str_keep   <= cfg_data_i;
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  // Advance the held byte only when the queue can take both of its results
  assign advance    = s1_valid_q && room;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_ch_q    <= ch_i;
      s1_start_q <= start_req_i;
    end
  end

  fjop_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .ch_i        (s1_ch_q),
    .start_i     (s1_start_q),
    .cfg_i       (cfg_q),
    .res0_o      (res0),
    .res1_o      (res1),
    .res_valid_o (res_valid)
  );

  fjop_rq #(
    .Depth (ResDepth)
  ) u_rq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (advance && res_valid[0]),
    .push1_i     (advance && res_valid[1]),
    .data0_i     (res0),
    .data1_i     (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (head)
  );

  assign event_res_o  = head.ev;
  assign text_char_o  = head.text;
  assign value_kind_o = head.kind;
  assign number_o     = $signed(head.num);
  assign flag_value_o = head.flag;
  assign pair_index_o = head.idx;
  assign error_code_o = head.err;
  assign last_o       = head.last;

endmodule

// File: rtl/fjop_core.sv
module fjop_core import fjop_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] ch_i,
  input  logic       start_i,
  input  cfg_t       cfg_i,
  output res_t       res0_o,
  output res_t       res1_o,
  output logic [1:0] res_valid_o
);

  phase_e      phase_q, phase_d, cur_phase;
  logic [7:0]  pairs_q, pairs_d, cur_pairs;
  logic [7:0]  kept_q, kept_d, cur_kept;
  logic        esc_q, esc_d, cur_esc;
  logic [1:0]  litw_q, litw_d, cur_litw;
  logic [2:0]  litp_q, litp_d, cur_litp;
  logic [63:0] mag_q, mag_d, cur_mag;
  logic        neg_q, neg_d, cur_neg;
  logic        saw_q, saw_d, cur_saw;
  logic        sat_q, sat_d, cur_sat;

  logic        ws;
  logic        kbody;
  logic [7:0]  keep;
  logic [1:0]  lw;
  logic [2:0]  lp;
  logic [2:0]  lp_next;
  logic [67:0] mag_x10;
  logic [67:0] mag_sum;
  logic [63:0] num_val;
  res_t        r0, r1;
  logic        v0, v1;

  // A start request clears the document state before the byte is parsed
  always_comb begin
    if (start_i) begin
      cur_phase = PH_OPEN;
      cur_pairs = '0;
      cur_kept  = '0;
      cur_esc   = 1'b0;
      cur_litw  = '0;
      cur_litp  = '0;
      cur_mag   = '0;
      cur_neg   = 1'b0;
      cur_saw   = 1'b0;
      cur_sat   = 1'b0;
    end else begin
      cur_phase = phase_q;
      cur_pairs = pairs_q;
      cur_kept  = kept_q;
      cur_esc   = esc_q;
      cur_litw  = litw_q;
      cur_litp  = litp_q;
      cur_mag   = mag_q;
      cur_neg   = neg_q;
      cur_saw   = saw_q;
      cur_sat   = sat_q;
    end
  end

  assign ws      = is_ws(ch_i);
  assign kbody   = (cur_phase == PH_KBODY);
  assign keep    = kbody ? cfg_i.key_keep : cfg_i.str_keep;
  assign lw      = (cur_litw == 2'd3) ? LIT_NULL : cur_litw;
  assign lp      = (cur_litp < lit_len(lw)) ? cur_litp : 3'd0;
  assign lp_next = lp + 3'd1;
  assign mag_x10 = {1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0};
  assign mag_sum = mag_x10 + {64'd0, ch_i[3:0]};

  // Saturate to the nearest 64-bit extreme
  always_comb begin
    if (cur_neg) begin
      num_val = (cur_mag >= MAG_CAP) ? MAG_CAP : (64'd0 - cur_mag);
    end else begin
      num_val = (cur_mag >= MAG_CAP) ? (MAG_CAP - 64'd1) : cur_mag;
    end
  end

  always_comb begin
    phase_d = cur_phase;
    pairs_d = cur_pairs;
    kept_d  = cur_kept;
    esc_d   = cur_esc;
    litw_d  = cur_litw;
    litp_d  = cur_litp;
    mag_d   = cur_mag;
    neg_d   = cur_neg;
    saw_d   = cur_saw;
    sat_d   = cur_sat;
    r0      = '0;
    r1      = '0;
    v0      = 1'b0;
    v1      = 1'b0;
    case (cur_phase)
      PH_OPEN: begin
        if (!ws) begin
          if (ch_i == CH_LBRACE) begin
            phase_d = PH_FIRST;
          end else begin
            v0      = 1'b1;
            r0      = mk_err(ERR_OBJECT);
            phase_d = PH_DONE;
          end
        end
      end
      PH_FIRST, PH_KEY: begin
        if (!ws) begin
          if (cur_phase == PH_FIRST && ch_i == CH_RBRACE) begin
            v0      = 1'b1;
            r0      = mk_ok(cur_pairs);
            phase_d = PH_DONE;
          end else if (cur_pairs >= cfg_i.pair_limit) begin
            v0      = 1'b1;
            r0      = mk_err(ERR_PAIRS);
            phase_d = PH_DONE;
          end else if (ch_i != CH_QUOTE) begin
            v0      = 1'b1;
            r0      = mk_err(ERR_KEY);
            phase_d = PH_DONE;
          end else begin
            kept_d  = '0;
            esc_d   = 1'b0;
            phase_d = PH_KBODY;
          end
        end
      end
      PH_KBODY, PH_SBODY: begin
        if (ch_i == CH_NUL) begin
          v0      = 1'b1;
          r0      = mk_err(kbody ? ERR_KEY : ERR_STRING);
          phase_d = PH_DONE;
        end else if (!cur_esc && ch_i == CH_QUOTE) begin
          if (kbody) begin
            phase_d = PH_COLON;
          end else begin
            v0      = 1'b1;
            r0      = mk_pair(KIND_STRING, 64'd0, 1'b0, cur_pairs);
            pairs_d = cur_pairs + 8'd1;
            phase_d = PH_AFTER;
          end
        end else if (!cur_esc && ch_i == CH_BSLASH) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          if (cur_kept < keep) begin
            v0     = 1'b1;
            r0     = mk_text(kbody ? EV_KEY : EV_STR, ch_i, cur_pairs);
            kept_d = cur_kept + 8'd1;
          end
        end
      end
      PH_COLON: begin
        if (!ws) begin
          if (ch_i == CH_COLON) begin
            phase_d = PH_VALUE;
          end else begin
            v0      = 1'b1;
            r0      = mk_err(ERR_COLON);
            phase_d = PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        if (!ws) begin
          if (ch_i == CH_QUOTE) begin
            kept_d  = '0;
            esc_d   = 1'b0;
            phase_d = PH_SBODY;
          end else if (ch_i == CH_LOW_T || ch_i == CH_LOW_F || ch_i == CH_LOW_N) begin
            litw_d  = (ch_i == CH_LOW_T) ? LIT_TRUE :
                      ((ch_i == CH_LOW_F) ? LIT_FALSE : LIT_NULL);
            litp_d  = 3'd1;
            phase_d = PH_LIT;
          end else begin
            mag_d = '0;
            neg_d = 1'b0;
            saw_d = 1'b0;
            sat_d = 1'b0;
            if (ch_i == CH_PLUS || ch_i == CH_MINUS) begin
              neg_d   = (ch_i == CH_MINUS);
              phase_d = PH_NUM;
            end else if (is_digit(ch_i)) begin
              mag_d   = {60'd0, ch_i[3:0]};
              saw_d   = 1'b1;
              phase_d = PH_NUM;
            end else begin
              v0      = 1'b1;
              r0      = mk_err(ERR_VALUE);
              phase_d = PH_DONE;
            end
          end
        end
      end
      PH_LIT: begin
        if (lp == 3'd0 || ch_i != lit_char(lw, lp)) begin
          v0      = 1'b1;
          r0      = mk_err(ERR_VALUE);
          phase_d = PH_DONE;
        end else begin
          litp_d = lp_next;
          if (lp_next >= lit_len(lw)) begin
            v0      = 1'b1;
            r0      = (lw == LIT_NULL) ? mk_pair(KIND_NULL, 64'd0, 1'b0, cur_pairs) :
                      mk_pair(KIND_BOOL, 64'd0, (lw == LIT_TRUE), cur_pairs);
            pairs_d = cur_pairs + 8'd1;
            phase_d = PH_AFTER;
          end
        end
      end
      PH_NUM: begin
        if (is_digit(ch_i)) begin
          saw_d = 1'b1;
          if (!cur_sat) begin
            if (mag_sum > {4'd0, MAG_CAP}) begin
              sat_d = 1'b1;
              mag_d = MAG_CAP;
            end else begin
              mag_d = mag_sum[63:0];
            end
          end
        end else if (!cur_saw) begin
          v0      = 1'b1;
          r0      = mk_err(ERR_VALUE);
          phase_d = PH_DONE;
        end else begin
          // The byte that ends the digits also counts as the byte after the value
          v0      = 1'b1;
          r0      = mk_pair(KIND_INT, num_val, 1'b0, cur_pairs);
          pairs_d = cur_pairs + 8'd1;
          phase_d = PH_AFTER;
          if (!ws) begin
            if (ch_i == CH_COMMA) begin
              phase_d = PH_KEY;
            end else if (ch_i == CH_RBRACE) begin
              v1      = 1'b1;
              r1      = mk_ok(pairs_d);
              phase_d = PH_DONE;
            end else begin
              v1      = 1'b1;
              r1      = mk_err(ERR_AFTER);
              phase_d = PH_DONE;
            end
          end
        end
      end
      PH_AFTER: begin
        if (!ws) begin
          if (ch_i == CH_COMMA) begin
            phase_d = PH_KEY;
          end else if (ch_i == CH_RBRACE) begin
            v0      = 1'b1;
            r0      = mk_ok(cur_pairs);
            phase_d = PH_DONE;
          end else begin
            v0      = 1'b1;
            r0      = mk_err(ERR_AFTER);
            phase_d = PH_DONE;
          end
        end
      end
      PH_DONE: begin
        phase_d = PH_DONE;
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase
    r0.last = !v1;
    r1.last = 1'b1;
  end

  assign res0_o      = r0;
  assign res1_o      = r1;
  assign res_valid_o = {v1, v0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      pairs_q <= '0;
      kept_q  <= '0;
      esc_q   <= 1'b0;
      litw_q  <= '0;
      litp_q  <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      saw_q   <= 1'b0;
      sat_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pairs_q <= pairs_d;
      kept_q  <= kept_d;
      esc_q   <= esc_d;
      litw_q  <= litw_d;
      litp_q  <= litp_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      saw_q   <= saw_d;
      sat_q   <= sat_d;
    end
  end

`ifndef SYNTHESIS
  a_two_results_start_with_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o[1] |-> res_valid_o[0] && res0_o.ev == EV_PAIR)
    else $error("second result without a pair-done first");

  a_error_ends_document: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o[0] && res0_o.ev == EV_ERR |=> phase_q == PH_DONE)
    else $error("error did not end the document");

  a_done_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !start_i && phase_q == PH_DONE |-> res_valid_o == 2'b00)
    else $error("result after the document ended");
`endif

endmodule

// File: rtl/fjop_rq.sv
module fjop_rq import fjop_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push0_i,
  input  logic push1_i,
  input  res_t data0_i,
  input  res_t data1_i,
  output logic room_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] PtrMax  = PW'(Depth - 1);
  localparam logic [CW-1:0] CntRoom = CW'(Depth - 2);
  localparam logic [CW-1:0] CntMax  = CW'(Depth);

  res_t          mem_q [Depth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_n1;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PtrMax) ? '0 : p + PW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= CntRoom);
  assign wr_ptr_n1   = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push1_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_n1);
    end else if (push0_i) begin
      wr_ptr_d = wr_ptr_n1;
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CW'(push0_i) + CW'(push1_i) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_n1] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push1_i |-> push0_i)
    else $error("second slot written without the first");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push0_i |-> room_o)
    else $error("push without room for two results");
`endif

endmodule
